@@ hw/rtl/usbcer_pkg.sv @@
// Package for the endpoint-0 control responder.
// Event codes, request codes, descriptor map, descriptor ROM contents and FSM type.
// No dependencies.
package usbcer_pkg;

   // packet size on EP0 and descriptor ROM depth
   localparam int unsigned PACKET_BYTES = 64;
   localparam int unsigned ROM_BYTES    = 512;

   typedef enum logic [2:0] {
      EV_SETUP = 3'd0,
      EV_IN    = 3'd1,
      EV_OUT   = 3'd2,
      EV_RESET = 3'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      HS_ACK   = 2'd0,
      HS_NAK   = 2'd1,
      HS_STALL = 2'd2
   } handshake_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_LOAD = 2'd1,
      ST_SEND = 2'd2
   } fsm_type;

   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESCR     = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
   localparam logic [7:0] REQ_GET_INTF      = 8'h0A;
   localparam logic [7:0] REQ_VENDOR_WINUSB = 8'h20;
   localparam logic [7:0] REQ_NONE          = 8'hFF;

   localparam logic [7:0] EP_2_IN  = 8'h82;
   localparam logic [7:0] EP_2_OUT = 8'h02;
   localparam logic [7:0] EP_1_IN  = 8'h81;
   localparam logic [7:0] WINUSB_INDEX = 8'h07;
   localparam logic [7:0] LEN_CLAMP = 8'hF0;

   localparam logic [8:0] OFS_DEV = 9'd0;   localparam logic [7:0] LEN_DEV = 8'd18;
   localparam logic [8:0] OFS_CFG = 9'd18;  localparam logic [7:0] LEN_CFG = 8'd32;
   localparam logic [8:0] OFS_LANG = 9'd50; localparam logic [7:0] LEN_LANG = 8'd4;
   localparam logic [8:0] OFS_MANU = 9'd54; localparam logic [7:0] LEN_MANU = 8'd8;
   localparam logic [8:0] OFS_PROD = 9'd62; localparam logic [7:0] LEN_PROD = 8'd36;
   localparam logic [8:0] OFS_SER = 9'd98;  localparam logic [7:0] LEN_SER = 8'd26;
   localparam logic [8:0] OFS_INTF = 9'd124; localparam logic [7:0] LEN_INTF = 8'd26;
   localparam logic [8:0] OFS_BOS = 9'd150; localparam logic [7:0] LEN_BOS = 8'd40;
   localparam logic [8:0] OFS_WIN = 9'd190; localparam logic [7:0] LEN_WIN = 8'd162;
   localparam int unsigned ROM_USED = 352;

   localparam logic [7:0] ROM_DATA [ROM_USED] = '{
      8'h12,8'h01,8'h10,8'h02,8'hEF,8'h02,8'h01,8'(PACKET_BYTES),
      8'h28,8'h0D,8'h04,8'h02,8'h00,8'h01,8'h01,8'h02,8'h03,8'h01,
      8'h09,8'h02,8'h20,8'h00,8'h01,8'h01,8'h00,8'h80,8'hFA,
      8'h09,8'h04,8'h00,8'h00,8'h02,8'hFF,8'h00,8'h00,8'h04,
      8'h07,8'h05,8'h02,8'h02,8'h40,8'h00,8'h00,
      8'h07,8'h05,8'h82,8'h02,8'h40,8'h00,8'h00,
      8'h04,8'h03,8'h09,8'h04,
      8'h08,8'h03,8'h41,8'h00,8'h52,8'h00,8'h4D,8'h00,
      8'h24,8'h03,8'h44,8'h00,8'h41,8'h00,8'h50,8'h00,8'h4C,8'h00,8'h69,8'h00,
      8'h6E,8'h00,8'h6B,8'h00,
      8'h20,8'h00,8'h43,8'h00,8'h4D,8'h00,8'h53,8'h00,8'h49,8'h00,8'h53,8'h00,
      8'h2D,8'h00,8'h44,8'h00,
      8'h41,8'h00,8'h50,8'h00,
      8'h1A,8'h03,8'h30,8'h00,8'h30,8'h00,8'h30,8'h00,8'h31,8'h00,8'h41,8'h00,
      8'h30,8'h00,8'h30,8'h00,8'h30,8'h00,8'h30,8'h00,8'h30,8'h00,8'h30,8'h00,
      8'h30,8'h00,
      8'h1A,8'h03,8'h43,8'h00,8'h4D,8'h00,8'h53,8'h00,8'h49,8'h00,8'h53,8'h00,
      8'h2D,8'h00,8'h44,8'h00,
      8'h41,8'h00,8'h50,8'h00,8'h20,8'h00,8'h76,8'h00,8'h32,8'h00,
      8'h05,8'h0F,8'h28,8'h00,8'h02,8'h07,8'h10,8'h02,8'h00,8'h00,8'h00,8'h00,
      8'h1C,8'h10,8'h05,8'h00,8'hDF,8'h60,8'hDD,8'hD8,8'h89,8'h45,8'hC7,
      8'h4C,8'h9C,8'hD2,8'h65,8'h9D,8'h9E,8'h64,8'h8A,8'h9F,8'h00,8'h00,8'h03,
      8'h06,8'hA2,8'h00,8'h20,8'h00,
      8'h0A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h03,8'h06,8'hA2,8'h00,
      8'h14,8'h00,8'h03,8'h00,8'h57,8'h49,8'h4E,8'h55,8'h53,8'h42,8'h00,8'h00,
      8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h84,8'h00,8'h04,8'h00,8'h07,8'h00,
      8'h2A,8'h00,8'h44,8'h00,
      8'h65,8'h00,8'h76,8'h00,8'h69,8'h00,8'h63,8'h00,8'h65,8'h00,8'h49,8'h00,
      8'h6E,8'h00,8'h74,8'h00,
      8'h65,8'h00,8'h72,8'h00,8'h66,8'h00,8'h61,8'h00,8'h63,8'h00,8'h65,8'h00,
      8'h47,8'h00,8'h55,8'h00,
      8'h49,8'h00,8'h44,8'h00,8'h73,8'h00,8'h00,8'h00,8'h50,8'h00,8'h7B,8'h00,
      8'h43,8'h00,8'h44,8'h00,
      8'h42,8'h00,8'h33,8'h00,8'h42,8'h00,8'h35,8'h00,8'h41,8'h00,8'h44,8'h00,
      8'h2D,8'h00,8'h32,8'h00,
      8'h39,8'h00,8'h33,8'h00,8'h42,8'h00,8'h2D,8'h00,8'h34,8'h00,8'h36,8'h00,
      8'h36,8'h00,8'h33,8'h00,
      8'h2D,8'h00,8'h41,8'h00,8'h41,8'h00,8'h33,8'h00,8'h36,8'h00,8'h2D,8'h00,
      8'h31,8'h00,8'h41,8'h00,
      8'h41,8'h00,8'h45,8'h00,8'h34,8'h00,8'h36,8'h00,8'h34,8'h00,8'h36,8'h00,
      8'h33,8'h00,8'h37,8'h00,
      8'h37,8'h00,8'h36,8'h00,8'h7D,8'h00,8'h00,8'h00,8'h00,8'h00
   };

   // ROM contents, zero beyond the programmed bytes
   function automatic logic [7:0] rom_byte(input int unsigned addr);
      logic [7:0] b;
      b = 8'h00;
      if (addr < ROM_USED) begin
         b = ROM_DATA[addr];
      end
      return b;
   endfunction

endpackage

@@ hw/rtl/usbcer_rom.sv @@
// Descriptor ROM: synchronous memory with a registered read port.
// Depends on usbcer_pkg for the descriptor bytes.
module usbcer_rom #(
   parameter int unsigned ROM_BYTES = 512
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(ROM_BYTES)-1:0] rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem [ROM_BYTES];
   logic [7:0] rd_data_ff;

   // contents fixed at elaboration
   always_comb begin
      for (int i = 0; i < ROM_BYTES; i++) begin
         mem[i] = usbcer_pkg::rom_byte(i);
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/usb_control_endpoint_responder_unit.sv @@
// Top level of the USB endpoint-0 control responder.
// Depends on usbcer_pkg and usbcer_rom.
//
//  channel | ports                 | transfer
//  request | start, busy, req_*    | start high while busy low
//  result  | rsp_strobe, rsp_*     | rsp_strobe high, one cycle, no back-pressure
//
// An event without data holds busy for the ROM read slot and one result; one that
// loads n descriptor bytes holds it for the ROM read slot and n results, one byte out per
// cycle after the first synchronous ROM read. The next event can be taken as soon as
// busy is low again.
// Reset clears all control and enumeration state; EP0 response returns to NAK.
// Results cannot be stalled; busy stays high until the last result has gone.
module usb_control_endpoint_responder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_event_kind,
   input  logic        req_setup_size_ok,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_value_word,
   input  logic [15:0] req_index_word,
   input  logic [15:0] req_length_word,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [1:0]  rsp_handshake,
   output logic [6:0]  rsp_tx_length,
   output logic        rsp_data_toggle,
   output logic [6:0]  rsp_device_address,
   output logic [7:0]  rsp_config_value,
   output logic        rsp_ep2_in_stalled,
   output logic        rsp_ep2_out_stalled,
   output logic        rsp_ep1_in_stalled
);

   localparam int unsigned AW = $clog2(usbcer_pkg::ROM_BYTES);

   // state
   usbcer_pkg::fsm_type state_ff, state_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [7:0]  saved_ff, saved_in;
   logic [6:0]  addr_ff, addr_in;
   logic [7:0]  cfg_ff, cfg_in;
   logic        enum_ff, enum_in;
   logic        toggle_ff, toggle_in;
   logic [2:0]  stall_ff, stall_in;
   logic [1:0]  resp_ff, resp_in;
   logic [6:0]  txlen_ff, txlen_in;
   // packet run
   logic [6:0]  count_ff, count_in;   // bytes to send this event
   logic [6:0]  sent_ff, sent_in;     // bytes sent so far
   logic        from_rom_ff, from_rom_in;
   logic [7:0]  fixed_byte_ff, fixed_byte_in; // byte when not from ROM
   logic [AW-1:0] base_ff, base_in;

   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [7:0]    rd_data;

   usbcer_rom #(.ROM_BYTES(usbcer_pkg::ROM_BYTES)) u_rom (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != usbcer_pkg::ST_IDLE);

   // chunk size from a remaining count
   function automatic logic [6:0] chunk(input logic [7:0] rem);
      logic [6:0] c;
      c = (rem > 8'(usbcer_pkg::PACKET_BYTES)) ? 7'(usbcer_pkg::PACKET_BYTES) : rem[6:0];
      return c;
   endfunction

   // event decode: next architectural state and packet run
   always_comb begin
      logic        st;
      logic [7:0]  rem;
      logic [4:0]  recip;
      logic [7:0]  vh, vl, il;
      logic        descr;
      logic [AW-1:0] ofs;
      logic [7:0]  dlen;
      logic [6:0]  n;
      st = 1'b0; rem = remaining_ff; recip = req_request_type[4:0];
      vh = req_value_word[15:8]; vl = req_value_word[7:0]; il = req_index_word[7:0];
      descr = 1'b0; ofs = '0; dlen = 8'd0; n = 7'd0;
      remaining_in = remaining_ff; cursor_in = cursor_ff; saved_in = saved_ff;
      addr_in = addr_ff; cfg_in = cfg_ff; enum_in = enum_ff; toggle_in = toggle_ff;
      stall_in = stall_ff; resp_in = resp_ff; txlen_in = txlen_ff;
      count_in = count_ff; from_rom_in = from_rom_ff; fixed_byte_in = fixed_byte_ff;
      base_in = base_ff;
      if (accept) begin
         from_rom_in = 1'b0; fixed_byte_in = 8'h00;
         unique case (req_event_kind)
            usbcer_pkg::EV_SETUP: begin
               if (!req_setup_size_ok) begin
                  st = 1'b1;
               end else begin
                  rem = (req_length_word > 16'(usbcer_pkg::LEN_CLAMP)) ?
                        usbcer_pkg::LEN_CLAMP : req_length_word[7:0];
                  saved_in = req_request_code;
                  if ((req_request_type & 8'h60) != 8'h00) begin
                     if (recip == 5'd0 && req_request_code != usbcer_pkg::REQ_VENDOR_WINUSB) begin
                        st = 1'b1;
                     end else if (recip == 5'd0 && il == usbcer_pkg::WINUSB_INDEX) begin
                        descr = 1'b1; ofs = AW'(usbcer_pkg::OFS_WIN);
                        dlen = usbcer_pkg::LEN_WIN;
                     end else begin
                        rem = 8'd0;
                     end
                  end else begin
                     priority case (req_request_code)
                        usbcer_pkg::REQ_GET_DESCR: begin
                           descr = 1'b1;
                           priority if (vh == 8'd1) begin
                              ofs = AW'(usbcer_pkg::OFS_DEV); dlen = usbcer_pkg::LEN_DEV;
                           end else if (vh == 8'd2) begin
                              ofs = AW'(usbcer_pkg::OFS_CFG); dlen = usbcer_pkg::LEN_CFG;
                           end else if (vh == 8'd15) begin
                              ofs = AW'(usbcer_pkg::OFS_BOS); dlen = usbcer_pkg::LEN_BOS;
                           end else if (vh == 8'd3 && vl == 8'd0) begin
                              ofs = AW'(usbcer_pkg::OFS_LANG); dlen = usbcer_pkg::LEN_LANG;
                           end else if (vh == 8'd3 && vl == 8'd1) begin
                              ofs = AW'(usbcer_pkg::OFS_MANU); dlen = usbcer_pkg::LEN_MANU;
                           end else if (vh == 8'd3 && vl == 8'd2) begin
                              ofs = AW'(usbcer_pkg::OFS_PROD); dlen = usbcer_pkg::LEN_PROD;
                           end else if (vh == 8'd3 && vl == 8'd3) begin
                              ofs = AW'(usbcer_pkg::OFS_SER); dlen = usbcer_pkg::LEN_SER;
                           end else if (vh == 8'd3 && vl == 8'd4) begin
                              ofs = AW'(usbcer_pkg::OFS_INTF); dlen = usbcer_pkg::LEN_INTF;
                           end else begin
                              descr = 1'b0; st = 1'b1;
                           end
                        end
                        usbcer_pkg::REQ_SET_ADDRESS: rem = vl;
                        usbcer_pkg::REQ_GET_CONFIG: begin
                           fixed_byte_in = cfg_ff;
                           n = (rem >= 8'd1) ? 7'd1 : 7'd0;
                        end
                        usbcer_pkg::REQ_SET_CONFIG: begin
                           cfg_in = vl;
                           if (vl != 8'd0) enum_in = 1'b1;
                        end
                        usbcer_pkg::REQ_GET_INTF: begin
                        end
                        usbcer_pkg::REQ_CLEAR_FEATURE: begin
                           if (recip != 5'd2) st = 1'b1;
                           else if (il == usbcer_pkg::EP_2_IN) stall_in[0] = 1'b0;
                           else if (il == usbcer_pkg::EP_2_OUT) stall_in[1] = 1'b0;
                           else if (il == usbcer_pkg::EP_1_IN) stall_in[2] = 1'b0;
                           else st = 1'b1;
                        end
                        usbcer_pkg::REQ_SET_FEATURE: begin
                           if (recip != 5'd2 || req_value_word != 16'd0) st = 1'b1;
                           else if (req_index_word == 16'(usbcer_pkg::EP_2_IN)) stall_in[0] = 1'b1;
                           else if (req_index_word == 16'(usbcer_pkg::EP_2_OUT)) stall_in[1] = 1'b1;
                           else if (req_index_word == 16'(usbcer_pkg::EP_1_IN)) stall_in[2] = 1'b1;
                           else st = 1'b1;
                        end
                        usbcer_pkg::REQ_GET_STATUS: begin
                           n = (rem >= 8'd2) ? 7'd2 : rem[6:0];
                        end
                        default: st = 1'b1;
                     endcase
                  end
                  if (descr) begin
                     if (rem > dlen) rem = dlen;
                     n = chunk(rem);
                     rem = rem - 8'(n);
                     base_in = ofs;
                     cursor_in = AW'((AW+1)'(ofs) + (AW+1)'(n));
                     from_rom_in = 1'b1;
                  end
                  remaining_in = rem;
               end
               toggle_in = 1'b1;
               if (st) begin
                  saved_in = usbcer_pkg::REQ_NONE;
                  resp_in = usbcer_pkg::HS_STALL;
                  n = 7'd0;
               end else begin
                  resp_in = usbcer_pkg::HS_ACK;
                  txlen_in = n;
               end
            end
            usbcer_pkg::EV_IN: begin
               if (saved_ff == usbcer_pkg::REQ_GET_DESCR ||
                   saved_ff == usbcer_pkg::REQ_VENDOR_WINUSB) begin
                  n = chunk(remaining_ff);
                  remaining_in = remaining_ff - 8'(n);
                  base_in = cursor_ff;
                  cursor_in = AW'((AW+1)'(cursor_ff) + (AW+1)'(n));
                  from_rom_in = 1'b1;
                  txlen_in = n;
                  toggle_in = ~toggle_ff;
               end else begin
                  if (saved_ff == usbcer_pkg::REQ_SET_ADDRESS) addr_in = remaining_ff[6:0];
                  else txlen_in = 7'd0;
                  resp_in = usbcer_pkg::HS_NAK;
                  toggle_in = 1'b0;
               end
            end
            usbcer_pkg::EV_RESET: begin
               resp_in = usbcer_pkg::HS_NAK;
               toggle_in = 1'b0;
               addr_in = 7'd0;
               stall_in = 3'd0;
            end
            default: begin
            end
         endcase
         count_in = n;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      sent_in = sent_ff;
      unique case (state_ff)
         usbcer_pkg::ST_IDLE: begin
            sent_in = 7'd0;
            if (accept) state_in = usbcer_pkg::ST_LOAD;
         end
         usbcer_pkg::ST_LOAD: state_in = usbcer_pkg::ST_SEND;
         usbcer_pkg::ST_SEND: begin
            sent_in = sent_ff + 7'd1;
            if (sent_ff + 7'd1 >= count_ff) state_in = usbcer_pkg::ST_IDLE;
         end
         default: state_in = usbcer_pkg::ST_IDLE;
      endcase
   end

   // ROM read address runs one byte ahead of the output
   always_comb begin
      rd_en = 1'b0;
      rd_addr = base_ff;
      unique case (state_ff)
         usbcer_pkg::ST_LOAD: rd_en = 1'b1;
         usbcer_pkg::ST_SEND: begin
            rd_en = 1'b1;
            rd_addr = AW'((AW+1)'(base_ff) + (AW+1)'(sent_ff) + (AW+1)'(1));
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usbcer_pkg::ST_IDLE;
         remaining_ff <= '0; cursor_ff <= '0; saved_ff <= '0; addr_ff <= '0;
         cfg_ff <= '0; enum_ff <= 1'b0; toggle_ff <= 1'b0; stall_ff <= '0;
         resp_ff <= usbcer_pkg::HS_NAK; txlen_ff <= '0;
         count_ff <= '0; sent_ff <= '0; from_rom_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         remaining_ff <= remaining_in; cursor_ff <= cursor_in; saved_ff <= saved_in;
         addr_ff <= addr_in; cfg_ff <= cfg_in; enum_ff <= enum_in;
         toggle_ff <= toggle_in; stall_ff <= stall_in; resp_ff <= resp_in;
         txlen_ff <= txlen_in; count_ff <= count_in; sent_ff <= sent_in;
         from_rom_ff <= from_rom_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fixed_byte_ff <= fixed_byte_in;
      base_ff <= base_in;
   end

   // result outputs
   logic any_data;
   logic is_last;
   assign any_data = (count_ff != 7'd0);
   assign is_last = (sent_ff + 7'd1 >= count_ff);
   always_comb begin
      rsp_strobe = (state_ff == usbcer_pkg::ST_SEND);
      rsp_data_byte = 8'h00;
      if (any_data) rsp_data_byte = from_rom_ff ? rd_data : fixed_byte_ff;
      rsp_byte_valid = any_data;
      rsp_last = is_last;
      rsp_handshake = is_last ? resp_ff : usbcer_pkg::HS_ACK;
      rsp_tx_length = txlen_ff;
      rsp_data_toggle = toggle_ff;
      rsp_device_address = addr_ff;
      rsp_config_value = cfg_ff;
      rsp_ep2_in_stalled = stall_ff[0];
      rsp_ep2_out_stalled = stall_ff[1];
      rsp_ep1_in_stalled = stall_ff[2];
   end

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("accept while busy");
   a_load_then_send: assert property (@(posedge clock) disable iff (reset)
      state_ff == usbcer_pkg::ST_LOAD |=> state_ff == usbcer_pkg::ST_SEND)
      else $error("load not followed by send");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 7'(usbcer_pkg::PACKET_BYTES)) else $error("packet too long");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !busy) else $error("not idle after last");

endmodule
